FILE: rtl/core/otmp_pkg.sv
// Shared types, register codes and reset values for the over-temperature supervisor.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package otmp_pkg;

  localparam int unsigned TempW = 12;
  localparam int unsigned TimeW = 32;

  // Supervisor states; the encoding is the state code reported on the output.
  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_OCCUPIED = 3'd1,
    ST_OVER_LOW = 3'd2,
    ST_PREWAIT  = 3'd3,
    ST_OVER_HI  = 3'd4,
    ST_WAIT_RST = 3'd5
  } state_e;

  // Configuration register indexes (byte address / 4).
  typedef enum logic [1:0] {
    REG_LOW_THR  = 2'd0,
    REG_HIGH_THR = 2'd1,
    REG_PREALARM = 2'd2,
    REG_ALARM    = 2'd3
  } reg_idx_e;

  localparam logic signed [TempW-1:0] LowThrReset  = 12'sd250;
  localparam logic signed [TempW-1:0] HighThrReset = 12'sd300;
  localparam logic [TimeW-1:0]        PrealarmReset = 32'd3000;
  localparam logic [TimeW-1:0]        AlarmReset    = 32'd5000;

  typedef struct packed {
    logic signed [TempW-1:0] temperature;
    logic                    occupied;
    logic                    button_pressed;
    logic [TimeW-1:0]        now_ms;
  } item_t;

  typedef struct packed {
    logic [2:0] state_code;
    logic       prealarm_on;
    logic       alarm_on;
    logic       led_on;
    logic       clear_button;
  } result_t;

  typedef struct packed {
    logic signed [TempW-1:0] low_threshold;
    logic signed [TempW-1:0] high_threshold;
    logic [TimeW-1:0]        prealarm_time;
    logic [TimeW-1:0]        alarm_time;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/otmp_cfg_regs.sv
// APB-style configuration registers: thresholds and timeouts.
// Depends on otmp_pkg.
`default_nettype none

module otmp_cfg_regs
  import otmp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  // Byte offset bits are ignored; every write lands on one of the four registers.
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_threshold  <= LowThrReset;
      cfg_q.high_threshold <= HighThrReset;
      cfg_q.prealarm_time  <= PrealarmReset;
      cfg_q.alarm_time     <= AlarmReset;
    end else if (wr_en) begin
      unique case (idx)
        REG_LOW_THR:  cfg_q.low_threshold  <= pwdata[TempW-1:0];
        REG_HIGH_THR: cfg_q.high_threshold <= pwdata[TempW-1:0];
        REG_PREALARM: cfg_q.prealarm_time  <= pwdata;
        REG_ALARM:    cfg_q.alarm_time     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LOW_THR:  prdata = {{(32-TempW){cfg_q.low_threshold[TempW-1]}}, cfg_q.low_threshold};
      REG_HIGH_THR: prdata = {{(32-TempW){cfg_q.high_threshold[TempW-1]}},
                              cfg_q.high_threshold};
      REG_PREALARM: prdata = cfg_q.prealarm_time;
      REG_ALARM:    prdata = cfg_q.alarm_time;
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/otmp_fsm.sv
// Supervisor state machine with its timers and flags; computes one step per item.
// Depends on otmp_pkg.
`default_nettype none

module otmp_fsm
  import otmp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic step_i,
  input  item_t     item_i,
  input  cfg_t      cfg_i,
  output result_t   res_o
);

  state_e           state_q, state_d;
  logic [TimeW-1:0] entry_q, entry_d;
  logic [TimeW-1:0] carried_q, carried_d;
  logic             pre_q, pre_d;
  logic             alarm_q, alarm_d;
  logic             lamp_q, lamp_d;
  logic             clear;

  logic [TimeW-1:0] elapsed;
  logic [TimeW:0]   carried_sum;
  logic             above_low, below_low, above_high, below_high;
  logic             gt_pre, gt_alarm, sum_gt_pre;

  // Elapsed time wraps at 32 bits; the carried sum is kept at 33 bits.
  assign elapsed     = item_i.now_ms - entry_q;
  assign carried_sum = {1'b0, elapsed} + {1'b0, carried_q};

  assign above_low  = item_i.temperature > cfg_i.low_threshold;
  assign below_low  = item_i.temperature < cfg_i.low_threshold;
  assign above_high = item_i.temperature > cfg_i.high_threshold;
  assign below_high = item_i.temperature < cfg_i.high_threshold;
  assign gt_pre     = elapsed > cfg_i.prealarm_time;
  assign gt_alarm   = elapsed > cfg_i.alarm_time;
  assign sum_gt_pre = carried_sum > {1'b0, cfg_i.prealarm_time};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_OCCUPIED: begin
        if (!item_i.occupied) state_d = ST_IDLE;
        else if (above_low)   state_d = ST_OVER_LOW;
      end
      ST_OVER_LOW: begin
        if (below_low)       state_d = ST_OCCUPIED;
        else if (gt_pre)     state_d = ST_PREWAIT;
        else if (above_high) state_d = ST_OVER_HI;
      end
      ST_OVER_HI: begin
        if (below_high)    state_d = ST_OVER_LOW;
        else if (gt_alarm) state_d = ST_WAIT_RST;
      end
      ST_PREWAIT: begin
        if (above_high)     state_d = ST_OVER_HI;
        else if (below_low) state_d = ST_OCCUPIED;
      end
      ST_WAIT_RST: begin
        if (item_i.button_pressed) state_d = ST_OCCUPIED;
      end
      default: begin
        // Idle, and any unused code, wait for the bay to be occupied.
        if (item_i.occupied) state_d = ST_OCCUPIED;
      end
    endcase
  end

  always_comb begin
    carried_d = carried_q;
    pre_d     = pre_q;
    alarm_d   = alarm_q;
    lamp_d    = lamp_q;
    clear     = 1'b0;
    // Every state change restarts the time in state.
    entry_d   = (state_d != state_q) ? item_i.now_ms : entry_q;
    unique case (state_q)
      ST_OCCUPIED: begin
        if (item_i.occupied && above_low) carried_d = '0;
      end
      ST_OVER_LOW: begin
        if (below_low) begin
          pre_d = 1'b0;
        end else if (gt_pre) begin
          carried_d = '0;
          pre_d     = 1'b1;
        end else if (above_high) begin
          carried_d = elapsed;
        end
      end
      ST_OVER_HI: begin
        if (!below_high && gt_alarm) begin
          alarm_d = 1'b1;
          lamp_d  = 1'b1;
          pre_d   = 1'b0;
          clear   = 1'b1;
        end else if (!below_high && sum_gt_pre) begin
          pre_d = 1'b1;
        end
      end
      ST_WAIT_RST: begin
        if (item_i.button_pressed) begin
          alarm_d = 1'b0;
          lamp_d  = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_OCCUPIED;
      entry_q   <= '0;
      carried_q <= '0;
      pre_q     <= 1'b0;
      alarm_q   <= 1'b0;
      lamp_q    <= 1'b0;
    end else if (step_i) begin
      state_q   <= state_d;
      entry_q   <= entry_d;
      carried_q <= carried_d;
      pre_q     <= pre_d;
      alarm_q   <= alarm_d;
      lamp_q    <= lamp_d;
    end
  end

  assign res_o.state_code   = state_d;
  assign res_o.prealarm_on  = pre_d;
  assign res_o.alarm_on     = alarm_d;
  assign res_o.led_on       = lamp_d;
  assign res_o.clear_button = clear;

endmodule

`default_nettype wire

FILE: rtl/core/overtemp_alarm_fsm.sv
// Over-temperature supervisor, top level.
// Use: each input item carries a temperature sample (signed tenths of a degree),
// the occupancy and button flags and the millisecond time of one tick. Each item
// yields exactly one result item: the state code after the tick, the pre-alarm,
// alarm and lamp flags, and a one-item button-clear pulse on alarm entry.
// Channels: stream input (s_axis_*), stream output (m_axis_*), and an APB-style
// port for thresholds and timeouts, to be written only while no item is in flight.
// Path: an accepted item is held in the input register and its result is computed
// into the output register, where it is valid to the receiver.
// Throughput: one item per cycle unless stalled; the state step is one pass of
// compare logic from the input register to the output register, with the wrapping
// 32-bit elapsed-time subtract and the 33-bit carried-time sum as the longest path.
// Stall: when the receiver holds m_axis_tready low, the result waits in the
// output register and one more item is held in the input register; then
// s_axis_tready drops until the receiver takes the result.
// Reset: the supervisor starts in the occupied state with timers and flags
// cleared, and the registers return to 25.0, 30.0 degrees, 3000 and 5000 ms.
// Depends on otmp_pkg, otmp_cfg_regs and otmp_fsm.
`default_nettype none

module overtemp_alarm_fsm
  import otmp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input item.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [11:0] temperature, [12] occupied, [13] button_pressed, [45:14] now_ms,
  // [47:46] zero.
  input  wire logic [47:0] s_axis_tdata,
  // Result item.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [2:0] state_code, [3] prealarm_on, [4] alarm_on, [5] led_on,
  // [6] clear_button, [7] zero.
  output logic [7:0]       m_axis_tdata,
  // Configuration.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t    cfg;
  item_t   item_q;
  logic    in_vld_q;
  result_t res, res_q;
  logic    out_vld_q;
  logic    advance;
  logic    in_take;

  // The held item steps the supervisor whenever the output register can take it.
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.temperature    <= s_axis_tdata[11:0];
      item_q.occupied       <= s_axis_tdata[12];
      item_q.button_pressed <= s_axis_tdata[13];
      item_q.now_ms         <= s_axis_tdata[45:14];
    end
  end

  otmp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  otmp_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, res_q.clear_button, res_q.led_on, res_q.alarm_on,
                          res_q.prealarm_on, res_q.state_code};

endmodule

`default_nettype wire
